>>> design/mm_pkg.sv
// package for the modular multiplier: widths and sequencer states
`default_nettype none

package mm_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MULT
	} mm_state_t;

endpackage

`default_nettype wire

>>> design/modular_multiplier.sv
// modular multiplier top level: sequencer, operand shift registers, result register
`default_nettype none

// A request is taken when start is high and busy is low. The block first reduces the
// multiplicand modulo the configured modulus, one bit per cycle, then forms the product
// by interleaved shift-add-reduce, one multiplier bit per cycle, both through the same
// serial step unit. After the last multiplier bit has been processed, done pulses
// for one cycle with the result; busy falls in that same cycle, so a new request may be
// issued while the result is shown. With a zero modulus the result comes in the cycle after
// the request, with product_mod 0 and modulus_zero set. The receiver cannot stall: the
// result must be captured in the cycle that done is high. The modulus resets to 1. The user
// must write it through cfg_we/cfg_wdata only while the block is idle; it is not enforced.

module modular_multiplier (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [mm_pkg::WIDTH-1:0] multiplicand,
	input  wire logic [mm_pkg::WIDTH-1:0] multiplier,
	input  wire logic                     cfg_we,
	input  wire logic [mm_pkg::WIDTH-1:0] cfg_wdata,
	output logic                          done,
	output logic      [mm_pkg::WIDTH-1:0] product_mod,
	output logic                          modulus_zero
);
	import mm_pkg::*;

	mm_state_t        state_q;
	mm_state_t        state_d;
	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [WIDTH-1:0] product_q;
	logic             zero_q;

	logic             accept;
	logic             last;
	logic             step_shift_in;
	logic [WIDTH-1:0] step_addend;
	logic [WIDTH-1:0] rem_next;

	assign accept = start && (state_q == ST_IDLE);
	assign last   = (cnt_q == '0);

	mm_step u_step (
		.rem      (rem_q),
		.shift_in (step_shift_in),
		.addend   (step_addend),
		.n        (modulus_q),
		.rem_next (rem_next)
	);

	always_comb begin
		state_d       = state_q;
		busy          = 1'b1;
		step_shift_in = 1'b0;
		step_addend   = '0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (modulus_q != '0)) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				step_shift_in = a_q[WIDTH-1];
				if (last) begin
					state_d = ST_MULT;
				end
			end
			ST_MULT: begin
				step_addend = b_q[WIDTH-1] ? a_q : '0;
				if (last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			modulus_q <= WIDTH'(1);
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= CNT_W'(WIDTH - 1);
					if (accept && (modulus_q == '0)) begin
						done_q <= 1'b1;
					end
				end
				ST_REDUCE: begin
					cnt_q <= last ? CNT_W'(WIDTH - 1) : cnt_q - 1'b1;
				end
				ST_MULT: begin
					cnt_q <= cnt_q - 1'b1;
					if (last) begin
						done_q <= 1'b1;
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_q   <= multiplicand;
				b_q   <= multiplier;
				rem_q <= '0;
				if (accept) begin
					product_q <= '0;
					zero_q    <= (modulus_q == '0);
				end
			end
			ST_REDUCE: begin
				// reduced multiplicand replaces the shifted-out operand
				if (last) begin
					a_q   <= rem_next;
					rem_q <= '0;
				end else begin
					a_q   <= {a_q[WIDTH-2:0], 1'b0};
					rem_q <= rem_next;
				end
			end
			ST_MULT: begin
				b_q   <= {b_q[WIDTH-2:0], 1'b0};
				rem_q <= rem_next;
				if (last) begin
					product_q <= rem_next;
				end
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	assign done         = done_q;
	assign product_mod  = product_q;
	assign modulus_zero = zero_q;

endmodule

`default_nettype wire

>>> design/mm_step.sv
// one serial step: shift the remainder left, add a digit, reduce modulo n
`default_nettype none

module mm_step (
	input  wire logic [mm_pkg::WIDTH-1:0] rem,
	input  wire logic                     shift_in,
	input  wire logic [mm_pkg::WIDTH-1:0] addend,
	input  wire logic [mm_pkg::WIDTH-1:0] n,
	output logic      [mm_pkg::WIDTH-1:0] rem_next
);
	import mm_pkg::*;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+2:0] diff1;
	logic [WIDTH+2:0] diff2;

	// sum stays below 3n, so at most two subtractions of n are needed
	always_comb begin
		sum   = {1'b0, rem, shift_in} + {2'b00, addend};
		diff1 = {1'b0, sum} - {3'b000, n};
		diff2 = {1'b0, sum} - {2'b00, n, 1'b0};
		if (!diff2[WIDTH+2]) begin
			rem_next = diff2[WIDTH-1:0];
		end else if (!diff1[WIDTH+2]) begin
			rem_next = diff1[WIDTH-1:0];
		end else begin
			rem_next = sum[WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

>>> verif/modular_multiplier_test.sv
// self-checking testbench for the modular multiplier: directed and random requests
`default_nettype none

module modular_multiplier_test;

	localparam int W = mm_pkg::WIDTH;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_REQUESTS = 80;
	localparam int MAX_GAP = 70;
	localparam int DRAIN_CYCLES = 2 * W + 8;
	localparam logic [W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [W-1:0] residue;
		logic         zero_flag;
	} residue_t;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic [W-1:0] multiplicand;
	logic [W-1:0] multiplier;
	logic         cfg_we;
	logic [W-1:0] cfg_wdata;
	logic         done;
	logic [W-1:0] product_mod;
	logic         modulus_zero;

	residue_t     pending_residues[$];
	logic [W-1:0] modulus_shadow = W'(1);
	int           mismatches = 0;
	int           cycle_count = 0;

	modular_multiplier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.multiplicand (multiplicand),
		.multiplier   (multiplier),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.product_mod  (product_mod),
		.modulus_zero (modulus_zero)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic residue_t predict_residue(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] n);
		logic [2*W-1:0] full;
		residue_t       r;
		r.zero_flag = (n == '0);
		r.residue   = '0;
		if (n != '0) begin
			full      = {{W{1'b0}}, a} * {{W{1'b0}}, b};
			r.residue = W'(full % {{W{1'b0}}, n});
		end
		return r;
	endfunction

	function automatic logic [W-1:0] random_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[W-1:0];
	endfunction

	function automatic logic [W-1:0] random_modulus();
		logic [W-1:0] n;
		case ($urandom_range(7))
			0: n = W'($urandom_range(2, 255));
			1: n = W'(1) << $urandom_range(0, W - 1);
			2: n = ALL_ONES - W'($urandom_range(0, 15));
			3: n = '0;
			4: n = W'(1);
			default: n = random_word();
		endcase
		return n;
	endfunction

	function automatic logic [W-1:0] random_operand(input logic [W-1:0] n);
		logic [W-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = ALL_ONES;
			2: v = n - W'(1);
			3, 4: v = (n == '0) ? random_word() : random_word() % n;
			default: v = random_word();
		endcase
		return v;
	endfunction

	// request acceptance and result checking
	always @(posedge clk) begin
		residue_t want;
		if (done) begin
			if (pending_residues.size() == 0) begin
				mismatches++;
				if (mismatches <= 50)
					$display("%0t: result expected none actual product_mod=%h modulus_zero=%b",
						$time, product_mod, modulus_zero);
			end else begin
				want = pending_residues.pop_front();
				if (product_mod !== want.residue) begin
					mismatches++;
					if (mismatches <= 50)
						$display("%0t: product_mod expected %h actual %h",
							$time, want.residue, product_mod);
				end
				if (modulus_zero !== want.zero_flag) begin
					mismatches++;
					if (mismatches <= 50)
						$display("%0t: modulus_zero expected %b actual %b",
							$time, want.zero_flag, modulus_zero);
				end
			end
		end
		if (arst_n && start && !busy)
			pending_residues.insert(pending_residues.size(),
				predict_residue(multiplicand, multiplier, modulus_shadow));
		if (arst_n && cfg_we)
			modulus_shadow = cfg_wdata;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send_request(input logic [W-1:0] a, input logic [W-1:0] b,
			input int idle_pct);
		if ($urandom_range(99) < idle_pct)
			idle_cycles($urandom_range(1, MAX_GAP));
		@(negedge clk);
		start        <= 1'b1;
		multiplicand <= a;
		multiplier   <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_residues.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_modulus(input logic [W-1:0] n);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_modulus();
		send_request(ALL_ONES, ALL_ONES, 0);
		send_request(W'(12345), W'(678), 0);
	endtask

	task automatic test_full_range_modulus();
		set_modulus(ALL_ONES);
		send_request('0, ALL_ONES, 0);
		send_request(ALL_ONES, '0, 0);
		send_request(ALL_ONES, ALL_ONES, 0);
		send_request(ALL_ONES - W'(1), ALL_ONES - W'(1), 0);
		send_request(W'(1), ALL_ONES - W'(1), 0);
		send_request({1'b1, {(W-1){1'b0}}}, {(W/2){2'b10}}, 0);
	endtask

	task automatic test_small_modulus();
		set_modulus(W'(251));
		send_request(W'(250), W'(250), 0);
		send_request(ALL_ONES, ALL_ONES, 0);
		send_request(W'(251), W'(7), 0);
		send_request({(W/2){2'b01}}, {(W/2){2'b10}}, 0);
	endtask

	task automatic test_power_of_two_modulus();
		set_modulus({1'b1, {(W-1){1'b0}}});
		send_request(ALL_ONES, ALL_ONES, 0);
		send_request({1'b1, {(W-1){1'b0}}}, W'(3), 0);
		send_request(W'(3), ALL_ONES, 0);
	endtask

	task automatic test_zero_modulus();
		set_modulus('0);
		send_request('0, '0, 0);
		send_request(ALL_ONES, ALL_ONES, 0);
		send_request(W'(5), W'(9), 0);
	endtask

	task automatic test_modulus_one();
		set_modulus(W'(1));
		send_request(ALL_ONES, ALL_ONES, 0);
		send_request(W'(2), W'(3), 0);
	endtask

	task automatic test_random_requests();
		logic [W-1:0] n;
		int           idle_pct;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			n = random_modulus();
			set_modulus(n);
			case (phase % 3)
				0: idle_pct = 0;
				1: idle_pct = 45;
				default: idle_pct = 19;
			endcase
			for (int i = 0; i < PHASE_REQUESTS; i++)
				send_request(random_operand(n), random_operand(n), idle_pct);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		multiplicand = '0;
		multiplier   = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_modulus();
		test_full_range_modulus();
		test_small_modulus();
		test_power_of_two_modulus();
		test_zero_modulus();
		test_modulus_one();
		test_random_requests();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

>>> modular_multiplier.f
design/mm_pkg.sv
design/mm_step.sv
design/modular_multiplier.sv
verif/modular_multiplier_test.sv
